[rtl/core/rolr_pkg.sv]
package rolr_pkg;

  localparam logic [10:0] OBJECT_IDENT_RESET = 11'h60B;
  localparam logic [10:0] STATUS_IDENT_RESET = 11'h60A;
  localparam logic [3:0]  FRAME_DLC          = 4'd8;

  // Configuration register indexes.
  localparam logic CFG_OBJECT_IDENT = 1'b0;
  localparam logic CFG_STATUS_IDENT = 1'b1;

  localparam logic signed [14:0] LONG_OFFSET_DM = 15'sd5000;
  localparam logic signed [12:0] LAT_OFFSET_DM  = 13'sd2042;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } drain_state_t;

  // Raw object as kept in the store, most significant field first.
  typedef struct packed {
    logic [7:0]  rcs;
    logic [2:0]  dyn;
    logic [1:0]  cls;
    logic [8:0]  vlat;
    logic [9:0]  vlong;
    logic [10:0] lat;
    logic [12:0] lng;
    logic [7:0]  id;
  } target_word_t;

endpackage

[rtl/core/radar_object_list_receiver.sv]
// Object frames are written to the target store at the edge of their transfer while it has
// room; one frame per cycle is taken while no list is drained and no result is stalled.
// A status frame starts a drain: each stored object is read through the store's single read
// port in ST_FETCH, and its result is registered in ST_EMIT, which waits while the output
// is stalled. A status frame with an empty store gives its one result in the next cycle.
// Synchronous reset clears the count, announced total and cycle copy and restores the
// default identifiers.
module radar_object_list_receiver #(
  parameter int MAX_TARGETS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [10:0]         frame_ident,
  input  logic [3:0]          frame_length,
  input  logic [7:0]          data_byte0,
  input  logic [7:0]          data_byte1,
  input  logic [7:0]          data_byte2,
  input  logic [7:0]          data_byte3,
  input  logic [7:0]          data_byte4,
  input  logic [7:0]          data_byte5,
  input  logic [7:0]          data_byte6,
  input  logic [7:0]          data_byte7,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                last_of_list,
  output logic [8:0]          target_number,
  output logic signed [14:0]  range_long_dm,
  output logic signed [12:0]  range_lat_dm,
  output logic signed [9:0]   speed_long_qms,
  output logic signed [8:0]   speed_lat_qms,
  output logic [1:0]          target_class,
  output logic [2:0]          motion_property,
  output logic signed [7:0]   cross_section_half_db,
  output logic                list_complete,
  output logic [7:0]          announced_total,
  output logic [15:0]         measure_cycle
);
  import rolr_pkg::*;

  localparam int CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_TARGETS);

  target_word_t target_store [MAX_TARGETS];
  target_word_t rd_word;
  target_word_t wr_word;

  drain_state_t state, state_next;

  logic [10:0]      object_ident;
  logic [10:0]      status_ident;
  logic [CNT_W-1:0] received_count;
  logic [7:0]       expected_total;
  logic [15:0]      cycle_counter_copy;

  logic [CNT_W-1:0] drain_count;
  logic [IDX_W-1:0] drain_idx;
  logic [IDX_W-1:0] drain_idx_next;
  logic             snap_complete;
  logic [7:0]       snap_total;
  logic [15:0]      snap_cycle;

  logic in_xfer;
  logic out_free;
  logic is_object;
  logic is_status;
  logic store_write;
  logic load_empty;
  logic load_target;
  logic drain_last;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign is_object = (frame_length == FRAME_DLC) && (frame_ident == object_ident);
  assign is_status = (frame_length == FRAME_DLC) && (frame_ident != object_ident) &&
                     (frame_ident == status_ident);
  assign store_write = in_xfer && is_object && (received_count != CAPACITY);
  assign drain_last  = (CNT_W'(drain_idx) + CNT_W'(1)) == drain_count;

  assign wr_word = '{
    rcs:   data_byte7,
    dyn:   data_byte6[2:0],
    cls:   data_byte6[4:3],
    vlat:  {data_byte5[5:0], data_byte6[7:5]},
    vlong: {data_byte4, data_byte5[7:6]},
    lat:   {data_byte2[2:0], data_byte3},
    lng:   {data_byte1, data_byte2[7:3]},
    id:    data_byte0
  };

  always_ff @(posedge clk) begin
    if (store_write) begin
      target_store[received_count[IDX_W-1:0]] <= wr_word;
    end
    rd_word <= target_store[drain_idx];
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    load_empty     = 1'b0;
    load_target    = 1'b0;
    drain_idx_next = drain_idx;
    unique case (state)
      ST_IDLE: begin
        in_stall       = out_valid && out_stall;
        drain_idx_next = '0;
        if (in_xfer && is_status) begin
          if (received_count == '0) begin
            load_empty = 1'b1;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load_target    = 1'b1;
          drain_idx_next = drain_idx + IDX_W'(1);
          state_next     = drain_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      object_ident       <= OBJECT_IDENT_RESET;
      status_ident       <= STATUS_IDENT_RESET;
      received_count     <= '0;
      expected_total     <= '0;
      cycle_counter_copy <= '0;
      out_valid          <= 1'b0;
      drain_idx          <= '0;
    end else begin
      state     <= state_next;
      drain_idx <= drain_idx_next;
      if (cfg_write) begin
        if (cfg_index == CFG_OBJECT_IDENT) begin
          object_ident <= cfg_data;
        end else begin
          status_ident <= cfg_data;
        end
      end
      if (store_write) begin
        received_count <= received_count + CNT_W'(1);
      end else if (in_xfer && is_status) begin
        received_count     <= '0;
        expected_total     <= data_byte0;
        cycle_counter_copy <= {data_byte1, data_byte2};
      end
      if (load_empty || load_target) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The announced values and completeness flag of the finished list are held for the drain.
  always_ff @(posedge clk) begin
    if (in_xfer && is_status) begin
      drain_count   <= received_count;
      snap_complete <= {{(8 - CNT_W){1'b0}}, received_count} == expected_total;
      snap_total    <= expected_total;
      snap_cycle    <= cycle_counter_copy;
    end
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      last_of_list          <= 1'b1;
      target_number         <= '0;
      range_long_dm         <= '0;
      range_lat_dm          <= '0;
      speed_long_qms        <= '0;
      speed_lat_qms         <= '0;
      target_class          <= '0;
      motion_property       <= '0;
      cross_section_half_db <= '0;
      list_complete         <= {{(8 - CNT_W){1'b0}}, received_count} == expected_total;
      announced_total       <= expected_total;
      measure_cycle         <= cycle_counter_copy;
    end else if (load_target) begin
      last_of_list          <= drain_last;
      target_number         <= {1'b0, rd_word.id} + 9'd1;
      range_long_dm         <= $signed({1'b0, rd_word.lng, 1'b0}) - LONG_OFFSET_DM;
      range_lat_dm          <= $signed({1'b0, rd_word.lat, 1'b0}) - LAT_OFFSET_DM;
      // Subtracting half the raw range only flips the top bit.
      speed_long_qms        <= $signed({~rd_word.vlong[9], rd_word.vlong[8:0]});
      speed_lat_qms         <= $signed({~rd_word.vlat[8], rd_word.vlat[7:0]});
      target_class          <= rd_word.cls;
      motion_property       <= rd_word.dyn;
      cross_section_half_db <= $signed({~rd_word.rcs[7], rd_word.rcs[6:0]});
      list_complete         <= snap_complete;
      announced_total       <= snap_total;
      measure_cycle         <= snap_cycle;
    end
  end

endmodule
